// ===== rtl/core/glmf_pkg.sv =====
// Shared constants and types for the grid local maximum finder.
package glmf_pkg;

   localparam int CSR_W       = 6;
   localparam int CSR_IDX_W   = 1;
   localparam int OUT_ROW_W   = 5;
   localparam int OUT_COL_W   = 5;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT = 1'b1;

   localparam logic [CSR_W-1:0] SIZE_RESET = 6'd32;

   // peak: the row above has a peak at this column
   // drain: final pixel, last-row mask travels along
   typedef struct packed {
      logic peak;
      logic drain;
   } glmf_flags_type;

endpackage

// ===== rtl/core/glmf_front.sv =====
// Front end: frame position, line store, neighbor compare and last-row marks.
module glmf_front #(
   parameter int MAX_ROWS   = 32,
   parameter int MAX_COLS   = 32,
   parameter int VALUE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [VALUE_BITS-1:0]          req_pixel_value,
   input  logic                                  csr_write,
   input  logic [glmf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [glmf_pkg::CSR_W-1:0]            csr_wdata,
   input  logic                                  queue_full,
   output logic                                  push,
   output glmf_pkg::glmf_flags_type              entry_flags,
   output logic [$clog2(MAX_ROWS)-1:0]           entry_row,
   output logic [$clog2(MAX_COLS)-1:0]           entry_col,
   output logic [MAX_COLS-1:0]                   entry_mask
);
   import glmf_pkg::*;

   localparam int RPW = $clog2(MAX_ROWS);
   localparam int CPW = $clog2(MAX_COLS);
   localparam int CNW = CSR_W + 1;
   localparam int RNW = (RPW + 1 > CNW) ? RPW + 1 : CNW;

   logic [CSR_W-1:0]             row_count_ff, row_count_in;
   logic [CSR_W-1:0]             col_count_ff, col_count_in;
   logic [RNW-1:0]               rows_eff, row_next;
   logic [CNW-1:0]               cols_eff, col_next, col_in_p1;
   logic [RPW-1:0]               row_ff, row_in;
   logic [CPW-1:0]               col_ff, col_in, right_idx;
   logic signed [VALUE_BITS-1:0] left_value_ff, left_value_in;
   logic signed [VALUE_BITS-1:0] row_first_ff, row_first_in;
   logic signed [VALUE_BITS-1:0] left_prev_ff, left_prev_in;
   logic signed [VALUE_BITS-1:0] mid_prev_ff, mid_prev_in;
   logic signed [VALUE_BITS-1:0] older_rd_ff, right_rd_ff;
   logic signed [VALUE_BITS-1:0] prev_mid, cur;
   logic [MAX_COLS-1:0]          marks_ff, marks_in, marks_next;
   logic                         accept, last_row, last_col, final_px;
   logic                         upper_peak, mark, right_in_range, right_hit;
   logic signed [VALUE_BITS-1:0] line_mem [2][MAX_COLS];

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign cur       = req_pixel_value;

   always_comb begin
      priority if (row_count_ff == '0) begin
         rows_eff = RNW'(1);
      end else if (RNW'(row_count_ff) > RNW'(MAX_ROWS)) begin
         rows_eff = RNW'(MAX_ROWS);
      end else begin
         rows_eff = RNW'(row_count_ff);
      end
      priority if (col_count_ff == '0) begin
         cols_eff = CNW'(1);
      end else if (CNW'(col_count_ff) > CNW'(MAX_COLS)) begin
         cols_eff = CNW'(MAX_COLS);
      end else begin
         cols_eff = CNW'(col_count_ff);
      end
   end

   assign row_next = RNW'(row_ff) + RNW'(1);
   assign col_next = CNW'(col_ff) + CNW'(1);
   assign last_row = (row_next == rows_eff);
   assign last_col = (col_next == cols_eff);
   assign final_px = last_row && last_col;

   // row above: value at this column comes from the row-start register at column 0
   assign prev_mid = (col_ff == '0) ? row_first_ff : mid_prev_ff;

   assign upper_peak = (row_ff != '0) && (prev_mid >= cur)
                    && ((row_ff <= RPW'(1)) || (prev_mid >= older_rd_ff))
                    && ((col_ff == '0) || (prev_mid >= left_prev_ff))
                    && (last_col || (prev_mid >= right_rd_ff));

   assign mark = ((row_ff == '0) || (cur >= prev_mid))
              && ((col_ff == '0) || (cur >= left_value_ff));

   always_comb begin
      marks_next = marks_ff;
      if (last_row) begin
         if ((col_ff != '0) && (left_value_ff < cur)) begin
            marks_next[col_ff - CPW'(1)] = 1'b0;
         end
         marks_next[col_ff] = mark;
      end
   end

   always_comb begin
      row_count_in  = row_count_ff;
      col_count_in  = col_count_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      left_value_in = left_value_ff;
      marks_in      = marks_ff;
      row_first_in  = row_first_ff;
      left_prev_in  = left_prev_ff;
      mid_prev_in   = mid_prev_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_ROW_COUNT: row_count_in = csr_wdata;
            CSR_COL_COUNT: col_count_in = csr_wdata;
            default:       row_count_in = row_count_ff;
         endcase
         row_in        = '0;
         col_in        = '0;
         left_value_in = '0;
         marks_in      = '0;
      end else if (accept) begin
         left_value_in = cur;
         left_prev_in  = prev_mid;
         mid_prev_in   = right_rd_ff;
         if (col_ff == '0) begin
            row_first_in = cur;
         end
         if (final_px) begin
            row_in   = '0;
            col_in   = '0;
            marks_in = '0;
         end else begin
            marks_in = marks_next;
            if (last_col) begin
               col_in = '0;
               row_in = row_next[RPW-1:0];
            end else begin
               col_in = col_next[CPW-1:0];
            end
         end
      end
   end

   // reads are set up for the next position
   assign col_in_p1      = CNW'(col_in) + CNW'(1);
   assign right_idx      = col_in_p1[CPW-1:0];
   assign right_in_range = (col_in_p1 < CNW'(MAX_COLS));
   assign right_hit      = accept && (row_ff[0] != row_in[0]) && (col_ff == right_idx);

   always_ff @(posedge clock) begin
      if (accept) begin
         line_mem[row_ff[0]][col_ff] <= cur;
      end
      older_rd_ff <= line_mem[row_in[0]][col_in];
      if (right_hit) begin
         right_rd_ff <= cur;
      end else if (right_in_range) begin
         right_rd_ff <= line_mem[~row_in[0]][right_idx];
      end else begin
         right_rd_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff  <= SIZE_RESET;
         col_count_ff  <= SIZE_RESET;
         row_ff        <= '0;
         col_ff        <= '0;
         left_value_ff <= '0;
         marks_ff      <= '0;
      end else begin
         row_count_ff  <= row_count_in;
         col_count_ff  <= col_count_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         left_value_ff <= left_value_in;
         marks_ff      <= marks_in;
      end
   end

   always_ff @(posedge clock) begin
      row_first_ff <= row_first_in;
      left_prev_ff <= left_prev_in;
      mid_prev_ff  <= mid_prev_in;
   end

   assign push              = accept && (upper_peak || (final_px && (marks_next != '0)));
   assign entry_flags.peak  = upper_peak;
   assign entry_flags.drain = final_px && (marks_next != '0);
   assign entry_row         = row_ff;
   assign entry_col         = col_ff;
   assign entry_mask        = marks_next;

   a_pos_in_frame: assert property (@(posedge clock) disable iff (reset)
      (RNW'(row_ff) < rows_eff) && (CNW'(col_ff) < cols_eff))
      else $error("frame position outside configured size");

   a_final_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && final_px && !csr_write) |=> (row_ff == '0) && (col_ff == '0)
                                           && (marks_ff == '0))
      else $error("frame did not restart after final pixel");

endmodule

// ===== rtl/core/glmf_queue.sv =====
// Short register queue between the front end and the result sequencer.
module glmf_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);
   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue pop while empty");

endmodule

// ===== rtl/core/glmf_back.sv =====
// Result sequencer: emits the upper-row peak and drains the last-row mask.
module glmf_back #(
   parameter int MAX_ROWS = 32,
   parameter int MAX_COLS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              head_valid,
   input  glmf_pkg::glmf_flags_type          head_flags,
   input  logic [$clog2(MAX_ROWS)-1:0]       head_row,
   input  logic [$clog2(MAX_COLS)-1:0]       head_col,
   input  logic [MAX_COLS-1:0]               head_mask,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [glmf_pkg::OUT_ROW_W-1:0]    rsp_peak_row,
   output logic [glmf_pkg::OUT_COL_W-1:0]    rsp_peak_col,
   output logic                              rsp_last_in_run
);
   import glmf_pkg::*;

   localparam int RPW = $clog2(MAX_ROWS);
   localparam int CPW = $clog2(MAX_COLS);
   localparam int ERW = (RPW > OUT_ROW_W) ? RPW : OUT_ROW_W;
   localparam int ECW = (CPW > OUT_COL_W) ? CPW : OUT_COL_W;

   logic                busy_ff, busy_in, peak_pend_ff, peak_pend_in;
   logic [RPW-1:0]      row_ff, row_in;
   logic [CPW-1:0]      col_ff, col_in, first_idx;
   logic [MAX_COLS-1:0] mask_ff, mask_in, mask_rest;
   logic [ERW-1:0]      row_ext, row_out;
   logic [ECW-1:0]      col_out;
   logic                rsp_accept, finish, run_end;

   always_comb begin
      first_idx = '0;
      for (int i = MAX_COLS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            first_idx = CPW'(i);
         end
      end
   end

   assign mask_rest  = mask_ff & (mask_ff - MAX_COLS'(1));
   assign rsp_accept = busy_ff && !rsp_stall;
   assign run_end    = peak_pend_ff ? (mask_ff == '0) : (mask_rest == '0);
   assign finish     = rsp_accept && run_end;
   assign pop        = head_valid && (!busy_ff || finish);

   assign row_ext = ERW'(row_ff);
   assign row_out = peak_pend_ff ? (row_ext - ERW'(1)) : row_ext;
   assign col_out = peak_pend_ff ? ECW'(col_ff) : ECW'(first_idx);

   assign rsp_valid       = busy_ff;
   assign rsp_peak_row    = row_out[OUT_ROW_W-1:0];
   assign rsp_peak_col    = col_out[OUT_COL_W-1:0];
   assign rsp_last_in_run = run_end;

   always_comb begin
      busy_in      = busy_ff;
      peak_pend_in = peak_pend_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      mask_in      = mask_ff;
      if (pop) begin
         busy_in      = 1'b1;
         peak_pend_in = head_flags.peak;
         row_in       = head_row;
         col_in       = head_col;
         mask_in      = head_flags.drain ? head_mask : '0;
      end else if (rsp_accept) begin
         busy_in = !finish;
         if (peak_pend_ff) begin
            peak_pend_in = 1'b0;
         end else begin
            mask_in = mask_rest;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         peak_pend_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         peak_pend_ff <= peak_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff  <= row_in;
      col_ff  <= col_in;
      mask_ff <= mask_in;
   end

   a_busy_has_work: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (peak_pend_ff || (mask_ff != '0)))
      else $error("sequencer holds an empty item");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && !rsp_last_in_run) |=> rsp_valid)
      else $error("run broke off before its last result");

endmodule

// ===== rtl/core/grid_local_max_finder_unit.sv =====
// Top level of the 4-neighbor grid local maximum finder.
// Throughput: one pixel per cycle; a frame's final pixel also yields a result for each last-row peak;
//   the input stalls only while the four-entry queue is full.
// Path: a result passes through a queue slot and then the sequencer registers before it is offered.
// Reset: synchronous; frame size returns to 32 by 32, position and marks clear,
//   queue empties; the line store is not cleared.
module grid_local_max_finder_unit #(
   parameter int MAX_ROWS   = 32,
   parameter int MAX_COLS   = 32,
   parameter int VALUE_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [VALUE_BITS-1:0]      req_pixel_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [glmf_pkg::OUT_ROW_W-1:0]    rsp_peak_row,
   output logic [glmf_pkg::OUT_COL_W-1:0]    rsp_peak_col,
   output logic                              rsp_last_in_run,
   input  logic                              csr_write,
   input  logic [glmf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [glmf_pkg::CSR_W-1:0]        csr_wdata
);
   import glmf_pkg::*;

   localparam int RPW = $clog2(MAX_ROWS);
   localparam int CPW = $clog2(MAX_COLS);

   typedef struct packed {
      glmf_flags_type      flags;
      logic [RPW-1:0]      row;
      logic [CPW-1:0]      col;
      logic [MAX_COLS-1:0] mask;
   } entry_type;

   entry_type in_entry, head_entry;
   logic      q_push, q_full, q_pop, q_valid;

   glmf_front #(
      .MAX_ROWS   (MAX_ROWS),
      .MAX_COLS   (MAX_COLS),
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_value (req_pixel_value),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .queue_full      (q_full),
      .push            (q_push),
      .entry_flags     (in_entry.flags),
      .entry_row       (in_entry.row),
      .entry_col       (in_entry.col),
      .entry_mask      (in_entry.mask)
   );

   glmf_queue #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (in_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (head_entry)
   );

   glmf_back #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (q_valid),
      .head_flags      (head_entry.flags),
      .head_row        (head_entry.row),
      .head_col        (head_entry.col),
      .head_mask       (head_entry.mask),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_peak_row    (rsp_peak_row),
      .rsp_peak_col    (rsp_peak_col),
      .rsp_last_in_run (rsp_last_in_run)
   );

endmodule
